[hdl/irtd_pkg.sv]
// Shared command and status types for the radical-by-trial-division block
`timescale 1ns / 1ps
`default_nettype none

package irtd_pkg;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;        // capture a new value, prime the trial divisor
		logic set_two;     // radical starts at 2 for even values
		logic shift_n;     // strip one factor 2
		logic div_start;   // start a division of n by d
		logic n_take_q;    // n takes the last quotient
		logic d_next;      // advance to the next odd divisor
		logic mul_start;   // start a multiply of the product
		logic mul_sel_n;   // multiply by n instead of d
		logic prod_take;   // product takes the multiplier result
		logic out_load;    // move the result into the output register
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic zero;        // value was zero
		logic n_even;      // remaining value is even
		logic n_gt1;       // remaining value is above one
		logic div_done;    // division finished this cycle
		logic d_gt_q;      // divisor exceeds quotient, search is over
		logic r_zero;      // divisor divides the remaining value
		logic mul_done;    // multiply finished this cycle
	} sts_t;

endpackage

`default_nettype wire

[hdl/irtd_div.sv]
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module irtd_div #(
	parameter int WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [WIDTH-1:0] dividend,
	input  wire logic [WIDTH-1:0] divisor,
	output logic                  done,
	output logic      [WIDTH-1:0] quotient,
	output logic      [WIDTH-1:0] remainder
);

	localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
	localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(WIDTH - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] dvs_q;
	logic [WIDTH:0]   shifted;
	logic [WIDTH:0]   diff;

	// trial subtraction of the divisor from the shifted remainder
	assign shifted = {rem_q, quo_q[WIDTH-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	// control: count one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= LAST_BIT;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// data: quotient bits shift in as dividend bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[WIDTH]) begin
				rem_q <= diff[WIDTH-1:0];
				quo_q <= {quo_q[WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= shifted[WIDTH-1:0];
				quo_q <= {quo_q[WIDTH-2:0], 1'b0};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

[hdl/irtd_mul.sv]
// Shift-and-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module irtd_mul #(
	parameter int WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [WIDTH-1:0] mcand,
	input  wire logic [WIDTH-1:0] mplier,
	output logic                  done,
	output logic      [WIDTH-1:0] product
);

	logic             busy_q;
	logic             done_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] mcand_q;
	logic [WIDTH-1:0] mplier_q;

	// control: run until the multiplier is used up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (mplier_q == '0)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// data: the true product fits, so upper bits are dropped
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= mcand;
			mplier_q <= mplier;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[WIDTH-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[WIDTH-1:1]};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

`default_nettype wire

[hdl/irtd_dpath.sv]
// Datapath: remaining value, trial divisor, product and result register
`timescale 1ns / 1ps
`default_nettype none

module irtd_dpath #(
	parameter int WIDTH = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire irtd_pkg::cmd_t      cmd,
	output irtd_pkg::sts_t           sts,
	input  wire logic    [WIDTH-1:0] value,
	output logic         [WIDTH-1:0] radical,
	output logic                     invalid
);

	import irtd_pkg::*;

	localparam logic [WIDTH-1:0] FIRST_ODD = WIDTH'(3);
	localparam logic [WIDTH-1:0] ODD_STEP  = WIDTH'(2);
	localparam logic [WIDTH-1:0] PROD_TWO  = WIDTH'(2);
	localparam logic [WIDTH-1:0] ONE       = WIDTH'(1);

	logic [WIDTH-1:0] n_q;
	logic [WIDTH-1:0] d_q;
	logic [WIDTH-1:0] prod_q;
	logic             zero_q;
	logic [WIDTH-1:0] radical_q;
	logic             invalid_q;

	logic [WIDTH-1:0] d_plus;
	logic [WIDTH-1:0] div_dvd;
	logic [WIDTH-1:0] div_dvs;
	logic [WIDTH-1:0] div_quo;
	logic [WIDTH-1:0] div_rem;
	logic             div_done;
	logic [WIDTH-1:0] mul_by;
	logic [WIDTH-1:0] mul_prod;
	logic             mul_done;

	// operands see updates made in the same cycle as the start
	assign d_plus  = d_q + ODD_STEP;
	assign div_dvd = cmd.n_take_q ? div_quo : n_q;
	assign div_dvs = cmd.d_next ? d_plus : d_q;
	assign mul_by  = cmd.mul_sel_n ? n_q : d_q;

	irtd_div #(.WIDTH(WIDTH)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	irtd_mul #(.WIDTH(WIDTH)) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mul_start),
		.mcand   (prod_q),
		.mplier  (mul_by),
		.done    (mul_done),
		.product (mul_prod)
	);

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q    <= value;
			d_q    <= FIRST_ODD;
			zero_q <= (value == '0);
			prod_q <= (value == '0) ? '0 : ONE;
		end else begin
			if (cmd.shift_n) begin
				n_q <= {1'b0, n_q[WIDTH-1:1]};
			end else if (cmd.n_take_q) begin
				n_q <= div_quo;
			end
			if (cmd.d_next) begin
				d_q <= d_plus;
			end
			if (cmd.set_two) begin
				prod_q <= PROD_TWO;
			end else if (cmd.prod_take) begin
				prod_q <= mul_prod;
			end
		end
	end

	// output register for the finished transaction
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			radical_q <= prod_q;
			invalid_q <= zero_q;
		end
	end

	assign sts.zero     = zero_q;
	assign sts.n_even   = ~n_q[0];
	assign sts.n_gt1    = (n_q > ONE);
	assign sts.div_done = div_done;
	assign sts.d_gt_q   = (d_q > div_quo);
	assign sts.r_zero   = (div_rem == '0);
	assign sts.mul_done = mul_done;

	assign radical = radical_q;
	assign invalid = invalid_q;

endmodule

`default_nettype wire

[hdl/irtd_ctrl.sv]
// Controller state machine for the trial-division sequence
`timescale 1ns / 1ps
`default_nettype none

module irtd_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           src_valid,
	output logic                src_stall,
	output logic                res_valid,
	input  wire logic           res_stall,
	output irtd_pkg::cmd_t      cmd,
	input  wire irtd_pkg::sts_t sts
);

	import irtd_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_START = 6'b000010,
		ST_STRIP = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_MUL   = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   strip_q;      // current divisor already found, dividing it out
	logic   strip_d;
	logic   final_q;      // multiply in flight is the last one
	logic   final_d;
	logic   res_valid_q;
	logic   out_free;

	assign out_free  = !res_valid_q || !res_stall;
	assign src_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		strip_d = strip_q;
		final_d = final_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (src_valid) begin
					cmd.load = 1'b1;
					strip_d  = 1'b0;
					final_d  = 1'b0;
					state_d  = ST_START;
				end
			end
			ST_START: begin
				if (sts.zero) begin
					state_d = ST_DONE;
				end else if (sts.n_even) begin
					cmd.set_two = 1'b1;
					state_d     = ST_STRIP;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_STRIP: begin
				if (sts.n_even) begin
					cmd.shift_n = 1'b1;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					if (strip_q) begin
						// keep dividing out the found factor
						cmd.div_start = 1'b1;
						if (sts.r_zero) begin
							cmd.n_take_q = 1'b1;
						end else begin
							cmd.d_next = 1'b1;
							strip_d    = 1'b0;
						end
					end else if (sts.d_gt_q) begin
						// leftover above one is a prime of its own
						if (sts.n_gt1) begin
							cmd.mul_start = 1'b1;
							cmd.mul_sel_n = 1'b1;
							final_d       = 1'b1;
							state_d       = ST_MUL;
						end else begin
							state_d = ST_DONE;
						end
					end else if (sts.r_zero) begin
						cmd.mul_start = 1'b1;
						cmd.n_take_q  = 1'b1;
						strip_d       = 1'b1;
						state_d       = ST_MUL;
					end else begin
						cmd.div_start = 1'b1;
						cmd.d_next    = 1'b1;
					end
				end
			end
			ST_MUL: begin
				if (sts.mul_done) begin
					cmd.prod_take = 1'b1;
					if (final_q) begin
						state_d = ST_DONE;
					end else begin
						cmd.div_start = 1'b1;
						state_d       = ST_DIV;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			strip_q     <= 1'b0;
			final_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			strip_q <= strip_d;
			final_q <= final_d;
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/integer_radical_trial_division.sv]
// Top level: radical of an unsigned integer by trial division
// Work: the bit-serial divider runs one division per trial divisor and one per factor removed,
// plus a shift-and-add multiply for each odd prime found.
// Handshake: one transaction at a time; the next is taken while a result waits.
// Reset: arst_n clears the controller and output valid, payload is not reset.
`timescale 1ns / 1ps
`default_nettype none

module integer_radical_trial_division #(
	parameter int WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             src_valid,
	output logic                  src_stall,
	input  wire logic [WIDTH-1:0] value,
	output logic                  res_valid,
	input  wire logic             res_stall,
	output logic      [WIDTH-1:0] radical,
	output logic                  invalid
);

	import irtd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	irtd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	irtd_dpath #(.WIDTH(WIDTH)) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.value   (value),
		.radical (radical),
		.invalid (invalid)
	);

endmodule

`default_nettype wire
